// ----- rtl/rqps_pkg.sv -----
// Shared types and constants of the ready queue policy selector.
`timescale 1ns / 1ps
package rqps_pkg;

    localparam int READY_DEPTH = 16;
    localparam int IDX_W       = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int CNT_W       = $clog2(READY_DEPTH + 1);
    localparam int APB_AW      = 3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [2:0]       t_mode;

    // Policy codes
    localparam t_mode POL_RR   = 3'd0;
    localparam t_mode POL_SJF  = 3'd1;
    localparam t_mode POL_SRTN = 3'd2;
    localparam t_mode POL_GUAR = 3'd3;
    localparam t_mode POL_PRIO = 3'd4;

    // Opcodes
    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_PICK = 1'b1;

    // Register index
    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic [7:0]         id;
        logic [15:0]        target;
        logic [15:0]        served;
        logic signed [15:0] prio;
    } t_entry;

    // Best-so-far token that travels down the chain during a scan
    typedef struct packed {
        logic   found;
        t_idx   idx;
        t_entry entry;
    } t_wave;

    typedef struct packed {
        logic valid;     // cell holds a live entry
        logic load_new;  // capture the incoming item
        logic shift;     // take the right neighbor's entry
        logic scan;      // advance the best token
    } t_cell_ctl;

endpackage

// ----- rtl/rqps_if.sv -----
// Handshake channels of the ready queue policy selector.
`timescale 1ns / 1ps
interface rqps_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         proc_id;
    logic [15:0]        target_time;
    logic [15:0]        served_time;
    logic signed [15:0] priority_level;

    modport source (output valid, opcode, proc_id, target_time, served_time, priority_level,
                    input ready);
    modport sink   (input valid, opcode, proc_id, target_time, served_time, priority_level,
                    output ready);
endinterface

interface rqps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] chosen_id;
    logic       chosen_valid;
    logic       full_error;
    logic [4:0] ready_count;

    modport source (output valid, chosen_id, chosen_valid, full_error, ready_count,
                    input ready);
    modport sink   (input valid, chosen_id, chosen_valid, full_error, ready_count,
                    output ready);
endinterface

// ----- rtl/ready_queue_policy_selector.sv -----
// Top level of the ready queue policy selector: table control and result staging.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one item per transfer: opcode 0 appends an entry (id, target,
//   served, priority) at the tail, opcode 1 removes one entry picked by the policy
//   held in the APB register at address 0 (0 round robin, 1 shortest job,
//   2 shortest remaining, 3 least served/target ratio, 4 highest priority).
//   out_ch returns exactly one result per input item, in order.
//   Throughput: one item at a time. An enqueue, or a pick on an empty table, goes
//   straight to result staging. A pick with entries first lets the best-so-far token
//   walk the row of cells, one cell per cycle, then closes the gap and stages the result.
//   Ties go to the earliest entry since a later cell only displaces on a strict win.
//   The result sits in an output register; a new item is taken while it waits, but
//   its own result is held until the receiver has taken the previous one.
//   Reset (synchronous, active low) empties the table and selects round robin;
//   table contents are not cleared, only the count.
module ready_queue_policy_selector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rqps_in_if.sink                     in_ch,
    rqps_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rqps_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rqps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_RESULT
    } t_state;

    t_state     r_state;
    t_cnt       r_count;
    t_idx       r_scan_cnt;
    logic [7:0] r_pend_id;
    logic       r_pend_valid;
    logic       r_pend_err;
    logic       r_out_valid;
    logic [7:0] r_out_id;
    logic       r_out_chosen;
    logic       r_out_err;
    logic [4:0] r_out_count;

    t_mode      mode;
    t_entry     new_entry;
    t_entry     ent_chain  [READY_DEPTH+1];
    t_wave      wave_chain [READY_DEPTH+1];
    t_cell_ctl  cell_ctl   [READY_DEPTH];
    t_wave      best;
    logic       in_xfer;
    logic       enq_ok;
    logic       table_full;

    rqps_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode)
    );

    // Take a new item only when no other is in flight.
    assign in_ch.ready = (r_state == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign table_full  = (r_count == CNT_W'(READY_DEPTH));
    assign enq_ok      = in_xfer && (in_ch.opcode == OP_ENQ) && !table_full;

    assign new_entry.id     = in_ch.proc_id;
    assign new_entry.target = in_ch.target_time;
    assign new_entry.served = in_ch.served_time;
    assign new_entry.prio   = in_ch.priority_level;

    // The token enters the row empty; the last cell's token is the winner.
    assign wave_chain[0]           = '0;
    assign ent_chain[READY_DEPTH]  = '0;
    assign best                    = wave_chain[READY_DEPTH];

    for (genvar g = 0; g < READY_DEPTH; g++) begin : g_cell
        always_comb begin
            cell_ctl[g].valid    = (CNT_W'(g) < r_count);
            cell_ctl[g].load_new = enq_ok && (CNT_W'(g) == r_count);
            // Close the gap: every entry past the winner moves up one slot.
            cell_ctl[g].shift    = (r_state == S_REMOVE) && (IDX_W'(g) >= best.idx)
                                   && (CNT_W'(g + 1) < r_count);
            cell_ctl[g].scan     = (r_state == S_SCAN);
        end

        rqps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[g]),
            .i_mode  (mode),
            .i_index (IDX_W'(g)),
            .i_new   (new_entry),
            .i_right (ent_chain[g+1]),
            .i_wave  (wave_chain[g]),
            .o_entry (ent_chain[g]),
            .o_wave  (wave_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_scan_cnt   <= '0;
            r_out_valid  <= 1'b0;
            r_pend_id    <= '0;
            r_pend_valid <= 1'b0;
            r_pend_err   <= 1'b0;
        end else begin
            // Stage a finished result, or drop the staged one once the receiver takes it.
            if (r_state == S_RESULT && (!r_out_valid || out_ch.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_pend_id    <= '0;
                        r_pend_valid <= 1'b0;
                        r_pend_err   <= 1'b0;
                        if (in_ch.opcode == OP_ENQ) begin
                            if (table_full) begin
                                r_pend_err <= 1'b1;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_RESULT;
                        end else if (r_count == '0) begin
                            r_state <= S_RESULT;
                        end else begin
                            r_scan_cnt <= IDX_W'(READY_DEPTH - 1);
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan_cnt == '0) begin
                        r_state <= S_REMOVE;
                    end else begin
                        r_scan_cnt <= r_scan_cnt - 1'b1;
                    end
                end
                S_REMOVE: begin
                    r_pend_id    <= best.entry.id;
                    r_pend_valid <= 1'b1;
                    r_count      <= r_count - 1'b1;
                    r_state      <= S_RESULT;
                end
                S_RESULT: begin
                    // Hold until the output register is free.
                    if (!r_out_valid || out_ch.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output payload follows the staged result; count is read after the update.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && (!r_out_valid || out_ch.ready)) begin
            r_out_id     <= r_pend_id;
            r_out_chosen <= r_pend_valid;
            r_out_err    <= r_pend_err;
            r_out_count  <= 5'(r_count);
        end
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.chosen_id    = r_out_id;
    assign out_ch.chosen_valid = r_out_chosen;
    assign out_ch.full_error   = r_out_err;
    assign out_ch.ready_count  = r_out_count;
endmodule

// ----- rtl/rqps_apb.sv -----
// APB-style register port holding the policy selection.
`timescale 1ns / 1ps
module rqps_apb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rqps_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rqps_pkg::t_mode            o_mode
);
    import rqps_pkg::*;

    t_mode r_mode;
    logic  hit;

    assign hit    = (paddr[2] == REG_POLICY);
    assign pready = 1'b1;
    assign o_mode = r_mode;
    assign prdata = hit ? {29'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= POL_RR;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_mode <= pwdata[2:0];
        end
    end
endmodule

// ----- rtl/rqps_cell.sv -----
// One slot of the ready table with its policy comparator.
`timescale 1ns / 1ps
module rqps_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rqps_pkg::t_cell_ctl i_ctl,
    input  rqps_pkg::t_mode     i_mode,
    input  rqps_pkg::t_idx      i_index,
    input  rqps_pkg::t_entry    i_new,
    input  rqps_pkg::t_entry    i_right,
    input  rqps_pkg::t_wave     i_wave,
    output rqps_pkg::t_entry    o_entry,
    output rqps_pkg::t_wave     o_wave
);
    import rqps_pkg::*;

    t_entry r_entry;
    t_wave  r_wave;
    t_wave  n_wave;
    logic   take_own;

    // True when candidate c displaces the current best b.
    function automatic logic beats(t_entry c, t_entry b, t_mode m);
        logic signed [16:0] rem_c;
        logic signed [16:0] rem_b;
        logic [31:0]        prod_c;
        logic [31:0]        prod_b;
        logic               res;
        rem_c  = $signed({1'b0, c.target}) - $signed({1'b0, c.served});
        rem_b  = $signed({1'b0, b.target}) - $signed({1'b0, b.served});
        prod_c = 32'(c.served) * 32'(b.target);
        prod_b = 32'(b.served) * 32'(c.target);
        unique case (m)
            POL_SJF:  res = c.target < b.target;
            POL_SRTN: res = rem_c < rem_b;
            POL_GUAR: res = prod_c < prod_b;
            POL_PRIO: res = c.prio > b.prio;
            default:  res = 1'b0;
        endcase
        return res;
    endfunction

    assign take_own = i_ctl.valid && (!i_wave.found || beats(r_entry, i_wave.entry, i_mode));

    always_comb begin
        n_wave = i_wave;
        if (take_own) begin
            n_wave.found = 1'b1;
            n_wave.idx   = i_index;
            n_wave.entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else if (i_ctl.scan) begin
            r_wave <= n_wave;
        end
    end

    assign o_entry = r_entry;
    assign o_wave  = r_wave;
endmodule
